// File: hdl/segment_reservation_table_assert.svh
// ----------------------------------------------------------------------------
// segment reservation table assertion macros
// shared property forms used by the reservation table checks
// ----------------------------------------------------------------------------
`ifndef SEGMENT_RESERVATION_TABLE_ASSERT_SVH
`define SEGMENT_RESERVATION_TABLE_ASSERT_SVH

// same-cycle implication, off during reset
`define SRT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srt check failed");

// next-cycle implication, off during reset
`define SRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srt check failed");

`endif

// File: hdl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// types, constants and helpers of the segment reservation table
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int SEGMENTS = 256;
  localparam int ENTRIES  = 256;
  localparam int ROBOTS   = 64;

  localparam int ACT_W  = 3;
  localparam int SEG_W  = 8;
  localparam int ROB_W  = 6;
  localparam int SIZE_W = 10;
  localparam int TIME_W = 16;
  localparam int STAT_W = 3;
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int FREE_W = SIZE_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET_CAP = 3'd0,
    ACT_CHECK   = 3'd1,
    ACT_ADD     = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_LOCATE  = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_CAPACITY  = 3'd1,
    ST_CONFLICT  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CAP,
    S_WALK,
    S_FIN
  } state_t;

  // one stored occupancy
  typedef struct packed {
    logic [SEG_W-1:0]  seg;
    logic [ROB_W-1:0]  robot;
    logic [SIZE_W-1:0] space;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
    logic              endless;
    logic              main;
  } entry_t;

  // request broadcast to every cell during a walk
  typedef struct packed {
    logic              locate;
    logic [SEG_W-1:0]  seg;
    logic [ROB_W-1:0]  robot;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
    logic              endless;
    logic [TIME_W-1:0] qtime;
  } query_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                     live;
    logic                     done;
    logic signed [FREE_W-1:0] free;
    logic [ROB_W-1:0]         robot;
    logic [SEG_W-1:0]         seg;
  } token_t;

  typedef struct packed {
    logic              ok;
    status_t           status;
    logic              cvalid;
    logic [ROB_W-1:0]  crobot;
    logic [SEG_W-1:0]  fseg;
  } result_t;

  function automatic logic overlaps(entry_t ent, query_t q);
    logic r;
    if (q.endless && ent.endless) begin
      r = 1'b1;
    end else if (q.endless) begin
      r = (q.start <= ent.stop);
    end else if (ent.endless) begin
      r = (q.stop >= ent.start);
    end else begin
      r = (q.start <= ent.start && q.stop >= ent.start) ||
          (q.start <= ent.stop && q.stop >= ent.stop) ||
          (q.start >= ent.start && q.stop <= ent.stop);
    end
    return r;
  endfunction

endpackage

// File: hdl/srt_intf.sv
// ----------------------------------------------------------------------------
// srt request and response channels
// valid/ready channels carrying the table's request and response fields
// ----------------------------------------------------------------------------
interface srt_req_if;
  import srt_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [SEG_W-1:0]  segment;
  logic [ROB_W-1:0]  robot;
  logic [SIZE_W-1:0] robot_size;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic              endless;
  logic              main_entry;
  logic              clamp_size;
  logic [SIZE_W-1:0] capacity_value;
  logic [TIME_W-1:0] query_time;

  modport source(output valid, action, segment, robot, robot_size, start_time,
                 end_time, endless, main_entry, clamp_size, capacity_value,
                 query_time, input ready);
  modport sink(input valid, action, segment, robot, robot_size, start_time,
               end_time, endless, main_entry, clamp_size, capacity_value,
               query_time, output ready);
endinterface

interface srt_rsp_if;
  import srt_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [STAT_W-1:0] status;
  logic              collision_valid;
  logic [ROB_W-1:0]  collision_robot;
  logic [SEG_W-1:0]  found_segment;

  modport source(output valid, ok, status, collision_valid, collision_robot,
                 found_segment, input ready);
  modport sink(input valid, ok, status, collision_valid, collision_robot,
               found_segment, output ready);
endinterface

// File: hdl/segment_reservation_table.sv
// ----------------------------------------------------------------------------
// segment_reservation_table
// timed segment occupancy table; requests walk a row of entry cells
// ----------------------------------------------------------------------------
// channel   dir  handshake     carries
// in_req    in   valid/ready   action and request fields
// out_rsp   out  valid/ready   ok, status, collision and located segment
//
// check, add and locate do one capacity read, then a token crosses the
// ENTRIES cells of the chain, one cell per cycle.
// set capacity, clear and unknown actions skip the capacity read and the walk.
// reset clears the pool count, cell valid bits and capacity valid bits.
// a new request is taken while the previous response waits in the output
// register; a stalled output holds the next result back.
module segment_reservation_table (
  input logic       clk,
  input logic       rst_n,
  srt_req_if.sink   in_req,
  srt_rsp_if.source out_rsp
);
  import srt_pkg::*;

  state_t state_r, state_nxt;

  logic [ACT_W-1:0]  act_r;
  entry_t            ent_r;
  logic              clamp_r;
  logic [TIME_W-1:0] qt_r;
  logic [CNT_W-1:0]  cnt_r;
  result_t           res_r, res_nxt;

  logic              out_valid_r;
  result_t           out_r;

  logic              accept;
  logic [SIZE_W-1:0] cap;
  logic [SIZE_W-1:0] size_eff;
  logic              cap_fail;
  logic              launch;
  logic              append;
  logic              clr;
  logic              walk_end;
  logic              fin_go;
  query_t            q;
  token_t            tok [ENTRIES+1];

  assign accept = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);

  srt_cap_mem u_cap (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && action_t'(in_req.action) == ACT_SET_CAP),
    .wr_addr (in_req.segment),
    .wr_data (in_req.capacity_value),
    .rd_en   (accept),
    .rd_addr (in_req.segment),
    .rd_data (cap)
  );

  // stays valid through the walk once the stored size is clamped
  assign size_eff = (clamp_r && ent_r.space > cap) ? cap : ent_r.space;
  assign cap_fail = (cap < size_eff) || (int'(ent_r.robot) >= ROBOTS) ||
                    (int'(ent_r.seg) >= SEGMENTS);

  assign q.locate  = (action_t'(act_r) == ACT_LOCATE);
  assign q.seg     = ent_r.seg;
  assign q.robot   = ent_r.robot;
  assign q.size    = size_eff;
  assign q.start   = ent_r.start;
  assign q.stop    = ent_r.stop;
  assign q.endless = ent_r.endless;
  assign q.qtime   = qt_r;

  assign tok[0].live  = launch;
  assign tok[0].done  = 1'b0;
  assign tok[0].free  = $signed({1'b0, cap});
  assign tok[0].robot = '0;
  assign tok[0].seg   = '0;

  assign walk_end = tok[ENTRIES].live;
  assign clr      = accept && action_t'(in_req.action) == ACT_CLEAR;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    srt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (append && cnt_r[IDX_W-1:0] == IDX_W'(i)),
      .clr     (clr),
      .wr_ent  (ent_r),
      .q       (q),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.action == ACT_CHECK || in_req.action == ACT_ADD ||
              in_req.action == ACT_LOCATE) begin
            state_nxt = S_CAP;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CAP: begin
        if (!q.locate && cap_fail) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    res_nxt  = res_r;
    launch   = 1'b0;
    append   = 1'b0;
    fin_go   = !out_valid_r || out_rsp.ready;
    case (state_r)
      S_IDLE: begin
        res_nxt = '0;
        if (in_req.action == ACT_SET_CAP || in_req.action == ACT_CLEAR) begin
          res_nxt.ok = 1'b1;
        end
      end
      S_CAP: begin
        if (!q.locate && cap_fail) begin
          res_nxt.status = ST_CAPACITY;
        end else begin
          launch = 1'b1;
        end
      end
      S_WALK: begin
        if (walk_end) begin
          if (q.locate) begin
            if (tok[ENTRIES].done) begin
              res_nxt.ok   = 1'b1;
              res_nxt.fseg = tok[ENTRIES].seg;
            end else begin
              res_nxt.status = ST_NOT_FOUND;
            end
          end else if (tok[ENTRIES].done) begin
            res_nxt.status = ST_CONFLICT;
            res_nxt.cvalid = 1'b1;
            res_nxt.crobot = tok[ENTRIES].robot;
          end else if (action_t'(act_r) == ACT_ADD &&
                       cnt_r >= CNT_W'(ENTRIES)) begin
            res_nxt.status = ST_FULL;
          end else begin
            res_nxt.ok = 1'b1;
            append     = (action_t'(act_r) == ACT_ADD);
          end
        end
      end
      S_FIN: begin
        res_nxt = res_r;
      end
      default: res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r         <= in_req.action;
      ent_r.seg     <= in_req.segment;
      ent_r.robot   <= in_req.robot;
      ent_r.space   <= in_req.robot_size;
      ent_r.start   <= in_req.start_time;
      ent_r.stop    <= in_req.end_time;
      ent_r.endless <= in_req.endless;
      ent_r.main    <= in_req.main_entry;
      clamp_r       <= in_req.clamp_size;
      qt_r          <= in_req.query_time;
    end else if (state_r == S_CAP) begin
      ent_r.space <= size_eff;
    end
    res_r  <= res_nxt;
    if (state_r == S_FIN && fin_go) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr) begin
        cnt_r <= '0;
      end else if (append) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == S_FIN && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.ok              = out_r.ok;
  assign out_rsp.status          = out_r.status;
  assign out_rsp.collision_valid = out_r.cvalid;
  assign out_rsp.collision_robot = out_r.crobot;
  assign out_rsp.found_segment   = out_r.fseg;

`include "segment_reservation_table_assert.svh"

  `SRT_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= CNT_W'(ENTRIES))
  `SRT_ASSERT_IMPL(a_tok_in_walk, tok[ENTRIES].live, state_r == S_WALK)
  `SRT_ASSERT_NEXT(a_accept_busy, accept, state_r != S_IDLE)
  `SRT_ASSERT_IMPL(a_conflict_robot, out_valid_r,
                   out_r.cvalid == (out_r.status == ST_CONFLICT))

endmodule

// File: hdl/srt_cap_mem.sv
// ----------------------------------------------------------------------------
// srt_cap_mem
// segment capacity store with per-segment valid bits, registered read
// ----------------------------------------------------------------------------
module srt_cap_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [srt_pkg::SEG_W-1:0] wr_addr,
  input  logic [srt_pkg::SIZE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [srt_pkg::SEG_W-1:0] rd_addr,
  output logic [srt_pkg::SIZE_W-1:0] rd_data
);
  import srt_pkg::*;

  logic [SIZE_W-1:0] mem [SEGMENTS];
  logic [SEGMENTS-1:0] vld_r;
  logic [SIZE_W-1:0] rd_q_r;
  logic              rd_v_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_v_r <= vld_r[rd_addr];
      end
    end
  end

  // never-written segment reads as zero capacity
  assign rd_data = rd_v_r ? rd_q_r : '0;

endmodule

// File: hdl/srt_cell.sv
// ----------------------------------------------------------------------------
// srt_cell
// one pool entry; updates the passing token and hands it on
// ----------------------------------------------------------------------------
module srt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  logic            clr,
  input  srt_pkg::entry_t wr_ent,
  input  srt_pkg::query_t q,
  input  srt_pkg::token_t tok_in,
  output srt_pkg::token_t tok_out
);
  import srt_pkg::*;

  logic   vld_r;
  entry_t ent_r;
  token_t tok_r, tok_nxt;
  logic signed [FREE_W-1:0] diff;

  always_comb begin
    tok_nxt = tok_in;
    diff    = tok_in.free - $signed({1'b0, ent_r.space});
    if (tok_in.live && !tok_in.done && vld_r) begin
      if (q.locate) begin
        if (ent_r.robot == q.robot && ent_r.main && q.qtime >= ent_r.start &&
            (ent_r.endless || q.qtime <= ent_r.stop)) begin
          tok_nxt.done = 1'b1;
          tok_nxt.seg  = ent_r.seg;
        end
      end else if (ent_r.seg == q.seg && ent_r.robot != q.robot &&
                   overlaps(ent_r, q)) begin
        tok_nxt.free = diff;
        if (diff < $signed({1'b0, q.size})) begin
          tok_nxt.done  = 1'b1;
          tok_nxt.robot = ent_r.robot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      tok_r <= '0;
    end else begin
      if (clr) begin
        vld_r <= 1'b0;
      end else if (wr_en) begin
        vld_r <= 1'b1;
      end
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
